### sv/polygon_sat_collision_defines.svh
// Assertion macros for the polygon SAT block.
`ifndef POLYGON_SAT_COLLISION_DEFINES_SVH
`define POLYGON_SAT_COLLISION_DEFINES_SVH

// Same-cycle implication, checked on clk, off during rst.
`define PSC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on clk, off during rst.
`define PSC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### sv/psc_pkg.sv
`default_nettype none
package psc_pkg;

  localparam int COORD_W = 32;
  localparam int EDGE_W  = COORD_W + 1;
  localparam int SEP_W   = 36;
  localparam int NOUT_W  = 16;
  localparam int DEPTH_W = 31;
  localparam int VTX_W   = 2 * COORD_W;

  typedef logic signed [COORD_W-1:0] coord_t;

  function automatic coord_t sat_coord(input logic signed [SEP_W+1:0] v);
    logic signed [SEP_W+1:0] hi;
    logic signed [SEP_W+1:0] lo;
    hi = (SEP_W+2)'(64'sh7FFF_FFFF);
    lo = -(SEP_W+2)'(64'sh8000_0000);
    if (v > hi) begin
      sat_coord = coord_t'(hi);
    end else if (v < lo) begin
      sat_coord = coord_t'(lo);
    end else begin
      sat_coord = v[COORD_W-1:0];
    end
  endfunction

endpackage
`default_nettype wire

### sv/psc_ram.sv
`default_nettype none
module psc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### sv/psc_norm.sv
`default_nettype none
// Unit outward normal of one edge: normalize, sum of squares, isqrt, two divides.
module psc_norm #(
  parameter int FRAC = 14,
  localparam int NW = FRAC + 2,
  localparam int EW = psc_pkg::EDGE_W
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic signed [EW-1:0] ex,
  input  wire logic signed [EW-1:0] ey,
  output logic                      done,
  output logic signed [NW-1:0]      nx,
  output logic signed [NW-1:0]      ny
);

  localparam int MW  = 30;
  localparam int SQW = 2 * MW + 2;
  localparam int LW  = MW + 1;
  localparam int RW  = LW + 1;
  localparam int DW  = MW + FRAC + 2;
  localparam int CNW = $clog2(NW + 1);

  typedef enum logic [7:0] {
    N_IDLE  = 8'b0000_0001,
    N_SHIFT = 8'b0000_0010,
    N_SQX   = 8'b0000_0100,
    N_SQY   = 8'b0000_1000,
    N_SQRT  = 8'b0001_0000,
    N_DSET  = 8'b0010_0000,
    N_DIV   = 8'b0100_0000,
    N_DONE  = 8'b1000_0000
  } nstate_t;

  nstate_t        state;
  logic [EW-1:0]  ux, uy, m;
  logic           xneg, yneg, second;
  logic [SQW-1:0] v, r, bitv, t;
  logic [DW-1:0]  nsh, nval;
  logic [RW-1:0]  rem;
  logic [RW:0]    rem2;
  logic           ge;
  logic [NW-1:0]  q, qx, qy;
  logic [CNW-1:0] cnt;
  logic [MW-1:0]  u;
  logic [LW-1:0]  len;

  assign m    = (ux > uy) ? ux : uy;
  assign t    = r + bitv;
  assign len  = r[LW-1:0];
  assign u    = second ? uy[MW-1:0] : ux[MW-1:0];
  assign nval = (DW'(u) << FRAC) + DW'(len >> 1);
  assign rem2 = {rem, nsh[FRAC+1]};
  assign ge   = rem2 >= (RW+1)'(len);
  assign done = (state == N_DONE);
  assign nx   = yneg ? -$signed(qy) : $signed(qy);
  assign ny   = xneg ? $signed(qx) : -$signed(qx);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= N_IDLE;
    end else begin
      unique case (state)
        N_IDLE: begin
          if (start) begin
            ux     <= ex[EW-1] ? EW'(-ex) : EW'(ex);
            uy     <= ey[EW-1] ? EW'(-ey) : EW'(ey);
            xneg   <= ex[EW-1];
            yneg   <= ey[EW-1];
            qx     <= '0;
            qy     <= '0;
            second <= 1'b0;
            state  <= (ex == '0 && ey == '0) ? N_DONE : N_SHIFT;
          end
        end
        N_SHIFT: begin
          if (m[EW-1:MW] != '0) begin
            ux <= ux >> 1;
            uy <= uy >> 1;
          end else if (!m[MW-1]) begin
            ux <= ux << 1;
            uy <= uy << 1;
          end else begin
            state <= N_SQX;
          end
        end
        N_SQX: begin
          v     <= SQW'(ux[MW-1:0] * ux[MW-1:0]);
          state <= N_SQY;
        end
        N_SQY: begin
          v     <= v + SQW'(uy[MW-1:0] * uy[MW-1:0]);
          r     <= '0;
          bitv  <= SQW'(1) << (SQW - 2);
          state <= N_SQRT;
        end
        N_SQRT: begin
          if (v >= t) begin
            v <= v - t;
            r <= (r >> 1) + bitv;
          end else begin
            r <= r >> 1;
          end
          bitv <= bitv >> 2;
          if (bitv[0]) begin
            state <= N_DSET;
          end
        end
        N_DSET: begin
          nsh   <= nval;
          rem   <= RW'(nval >> (FRAC + 2));
          q     <= '0;
          cnt   <= '0;
          state <= N_DIV;
        end
        N_DIV: begin
          nsh <= nsh << 1;
          rem <= ge ? RW'(rem2 - (RW+1)'(len)) : RW'(rem2);
          q   <= {q[NW-2:0], ge};
          cnt <= cnt + CNW'(1);
          if (cnt == CNW'(NW - 1)) begin
            if (!second) begin
              qx     <= {q[NW-2:0], ge};
              second <= 1'b1;
              state  <= N_DSET;
            end else begin
              qy    <= {q[NW-2:0], ge};
              state <= N_DONE;
            end
          end
        end
        N_DONE: begin
          state <= N_IDLE;
        end
        default: begin
          state <= N_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

### sv/polygon_sat_collision.sv
`default_nettype none
// Channel   Handshake            Fields
// item in   start / busy         which_polygon, vertex_x, vertex_y, last_vertex
// result    done (1-cycle)       collides, normal_x/y, start_x/y, end_x/y, depth
//
// A vertex that does not complete the pair is stored while busy stays low.
// The completing vertex runs the test: per edge the normal unit works (normalize shift,
// 31-step isqrt, two FRAC+2-step divides), then for each vertex of the other
// polygon S_RDV, S_MX, S_MY and S_CMP run on the shared multiplier, both ways.
// Sync reset empties both polygons. done is not held off by the receiver.
module polygon_sat_collision #(
  parameter int MAX_VERTICES     = 16,
  parameter int NORMAL_FRAC_BITS = 14
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic                                 which_polygon,
  input  wire logic signed [psc_pkg::COORD_W-1:0]   vertex_x,
  input  wire logic signed [psc_pkg::COORD_W-1:0]   vertex_y,
  input  wire logic                                 last_vertex,
  output logic                                      done,
  output logic                                      collides,
  output logic signed [psc_pkg::NOUT_W-1:0]         normal_x,
  output logic signed [psc_pkg::NOUT_W-1:0]         normal_y,
  output logic signed [psc_pkg::COORD_W-1:0]        start_x,
  output logic signed [psc_pkg::COORD_W-1:0]        start_y,
  output logic signed [psc_pkg::COORD_W-1:0]        end_x,
  output logic signed [psc_pkg::COORD_W-1:0]        end_y,
  output logic        [psc_pkg::DEPTH_W-1:0]        depth
);

  localparam int FRAC = NORMAL_FRAC_BITS;
  localparam int AW   = $clog2(MAX_VERTICES);
  localparam int CW   = $clog2(MAX_VERTICES + 1);
  localparam int NW   = FRAC + 2;
  localparam int CDW  = psc_pkg::COORD_W;
  localparam int EW   = psc_pkg::EDGE_W;
  localparam int SW   = psc_pkg::SEP_W;
  localparam int PW   = SW + NW;
  localparam int VW   = psc_pkg::VTX_W;
  localparam int XW   = (NW > psc_pkg::NOUT_W) ? NW : psc_pkg::NOUT_W;

  typedef enum logic [13:0] {
    S_IDLE = 14'b00_0000_0000_0001,
    S_RDA  = 14'b00_0000_0000_0010,
    S_RDB  = 14'b00_0000_0000_0100,
    S_NRM0 = 14'b00_0000_0000_1000,
    S_NRM  = 14'b00_0000_0001_0000,
    S_RDV  = 14'b00_0000_0010_0000,
    S_MX   = 14'b00_0000_0100_0000,
    S_MY   = 14'b00_0000_1000_0000,
    S_CMP  = 14'b00_0001_0000_0000,
    S_EDGE = 14'b00_0010_0000_0000,
    S_FIN  = 14'b00_0100_0000_0000,
    S_OFX  = 14'b00_1000_0000_0000,
    S_OFY  = 14'b01_0000_0000_0000,
    S_OUT  = 14'b10_0000_0000_0000
  } state_t;

  state_t state;

  logic [CW-1:0] count_a, count_b, eff_a, eff_b, np, nq;
  logic          a_complete, b_complete, a_next, b_next;
  logic          accept, we_a, we_b;
  logic [AW-1:0] ra_addr, rb_addr, i, j, k;
  logic [VW-1:0] ra_data, rb_data, p_data, q_data, wdata;
  logic          pass, i_last, j_last;

  logic signed [CDW-1:0] ax, ay, bx, by, px_d, py_d, qx_d, qy_d;
  logic signed [EW-1:0]  edx, edy;
  logic                  norm_done;
  logic signed [NW-1:0]  norm_x, norm_y, nxr, nyr;
  logic signed [SW-1:0]  mul_a;
  logic signed [NW-1:0]  mul_b;
  logic signed [PW-1:0]  prod, acc;
  logic signed [PW:0]    psum;
  logic signed [SW-1:0]  s, ms, best, sab, offx, offy;
  logic signed [CDW-1:0] mpx, mpy, bpx, bpy, apx, apy, cpx, cpy;
  logic signed [NW-1:0]  bnx, bny, anx, any_n, cnx, cny, onx, ony;
  logic signed [SW-1:0]  cdepth;
  logic                  use_ab;
  logic signed [XW-1:0]  onx_e, ony_e;
  logic signed [CDW-1:0] sx_o, sy_o, ex_o, ey_o, qpx, qpy;

  // ---------------- loading
  assign accept = start && !busy;
  assign eff_a  = a_complete ? '0 : count_a;
  assign eff_b  = b_complete ? '0 : count_b;
  assign we_a   = accept && !which_polygon && (eff_a < CW'(MAX_VERTICES));
  assign we_b   = accept && which_polygon && (eff_b < CW'(MAX_VERTICES));
  assign wdata  = {vertex_x, vertex_y};
  assign a_next = (accept && !which_polygon) ? last_vertex : a_complete;
  assign b_next = (accept && which_polygon) ? last_vertex : b_complete;
  assign busy   = (state != S_IDLE);

  psc_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_ram_a (
    .clk(clk), .we(we_a), .waddr(eff_a[AW-1:0]), .wdata(wdata),
    .raddr(ra_addr), .rdata(ra_data)
  );

  psc_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_ram_b (
    .clk(clk), .we(we_b), .waddr(eff_b[AW-1:0]), .wdata(wdata),
    .raddr(rb_addr), .rdata(rb_data)
  );

  // ---------------- pass routing: edges of P against vertices of Q
  assign np     = pass ? count_b : count_a;
  assign nq     = pass ? count_a : count_b;
  assign p_data = pass ? rb_data : ra_data;
  assign q_data = pass ? ra_data : rb_data;
  assign px_d   = p_data[VW-1:CDW];
  assign py_d   = p_data[CDW-1:0];
  assign qx_d   = q_data[VW-1:CDW];
  assign qy_d   = q_data[CDW-1:0];
  assign i_last = (CW'(i) + CW'(1) == np);
  assign j_last = (CW'(j) + CW'(1) == nq);
  assign k      = i_last ? '0 : i + AW'(1);

  always_comb begin
    logic [AW-1:0] pa, qa;
    pa = (state == S_RDB) ? k : i;
    qa = j;
    ra_addr = pass ? qa : pa;
    rb_addr = pass ? pa : qa;
  end

  assign edx = EW'(px_d) - EW'(ax);
  assign edy = EW'(py_d) - EW'(ay);

  psc_norm #(.FRAC(FRAC)) u_norm (
    .clk(clk), .rst(rst), .start(state == S_NRM0),
    .ex(edx), .ey(edy), .done(norm_done), .nx(norm_x), .ny(norm_y)
  );

  // ---------------- shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_MX: begin
        mul_a = SW'(EW'(qx_d) - EW'(ax));
        mul_b = nxr;
      end
      S_MY: begin
        mul_a = SW'(EW'(by) - EW'(ay));
        mul_b = nyr;
      end
      S_OFX: begin
        mul_a = cdepth;
        mul_b = cnx;
      end
      S_OFY: begin
        mul_a = cdepth;
        mul_b = cny;
      end
      S_FIN: begin
        mul_a = '0;
        mul_b = '0;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  assign psum = (PW+1)'(acc) + (PW+1)'(prod);
  assign s    = SW'(psum >>> FRAC);

  // ---------------- result forming
  assign onx   = use_ab ? cnx : -cnx;
  assign ony   = use_ab ? cny : -cny;
  assign onx_e = XW'(onx);
  assign ony_e = XW'(ony);
  assign qpx   = psc_pkg::sat_coord((SW+2)'(cpx) + (SW+2)'(offx));
  assign qpy   = psc_pkg::sat_coord((SW+2)'(cpy) + (SW+2)'(offy));
  assign offy  = SW'(prod >>> FRAC);
  assign sx_o  = use_ab ? cpx : qpx;
  assign sy_o  = use_ab ? cpy : qpy;
  assign ex_o  = use_ab ? qpx : cpx;
  assign ey_o  = use_ab ? qpy : cpy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count_a    <= '0;
      count_b    <= '0;
      a_complete <= 1'b0;
      b_complete <= 1'b0;
      done       <= 1'b0;
    end else begin
      done <= (state == S_OUT) ||
              ((state == S_FIN) && (!sab[SW-1] || !best[SW-1]));
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (!which_polygon) begin
              count_a <= we_a ? eff_a + CW'(1) : eff_a;
            end else begin
              count_b <= we_b ? eff_b + CW'(1) : eff_b;
            end
            a_complete <= a_next;
            b_complete <= b_next;
            if (a_next && b_next) begin
              pass  <= 1'b0;
              i     <= '0;
              state <= S_RDA;
            end
          end
        end
        S_RDA: state <= S_RDB;
        S_RDB: begin
          ax    <= px_d;
          ay    <= py_d;
          state <= S_NRM0;
        end
        S_NRM0: state <= S_NRM;
        S_NRM: begin
          if (norm_done) begin
            nxr   <= norm_x;
            nyr   <= norm_y;
            j     <= '0;
            state <= S_RDV;
          end
        end
        S_RDV: state <= S_MX;
        S_MX: begin
          bx    <= qx_d;
          by    <= qy_d;
          state <= S_MY;
        end
        S_MY: begin
          acc   <= prod;
          state <= S_CMP;
        end
        S_CMP: begin
          if (j == '0 || s < ms) begin
            ms  <= s;
            mpx <= bx;
            mpy <= by;
          end
          if (j_last) begin
            state <= S_EDGE;
          end else begin
            j     <= j + AW'(1);
            state <= S_RDV;
          end
        end
        S_EDGE: begin
          if (i == '0 || ms > best) begin
            best <= ms;
            bnx  <= nxr;
            bny  <= nyr;
            bpx  <= mpx;
            bpy  <= mpy;
          end
          if (!i_last) begin
            i     <= i + AW'(1);
            state <= S_RDA;
          end else if (!pass) begin
            if (i == '0 || ms > best) begin
              sab   <= ms;
              anx   <= nxr;
              any_n <= nyr;
              apx   <= mpx;
              apy   <= mpy;
            end else begin
              sab   <= best;
              anx   <= bnx;
              any_n <= bny;
              apx   <= bpx;
              apy   <= bpy;
            end
            pass  <= 1'b1;
            i     <= '0;
            state <= S_RDA;
          end else begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          count_a    <= '0;
          count_b    <= '0;
          a_complete <= 1'b0;
          b_complete <= 1'b0;
          use_ab     <= sab > best;
          if (!sab[SW-1] || !best[SW-1]) begin
            collides <= 1'b0;
            normal_x <= '0;
            normal_y <= '0;
            start_x  <= '0;
            start_y  <= '0;
            end_x    <= '0;
            end_y    <= '0;
            depth    <= '0;
            state    <= S_IDLE;
          end else begin
            if (sab > best) begin
              cdepth <= -sab;
              cnx    <= anx;
              cny    <= any_n;
              cpx    <= apx;
              cpy    <= apy;
            end else begin
              cdepth <= -best;
              cnx    <= bnx;
              cny    <= bny;
              cpx    <= bpx;
              cpy    <= bpy;
            end
            state <= S_OFX;
          end
        end
        S_OFX: state <= S_OFY;
        S_OFY: begin
          offx  <= SW'(prod >>> FRAC);
          state <= S_OUT;
        end
        S_OUT: begin
          collides <= 1'b1;
          normal_x <= onx_e[psc_pkg::NOUT_W-1:0];
          normal_y <= ony_e[psc_pkg::NOUT_W-1:0];
          start_x  <= sx_o;
          start_y  <= sy_o;
          end_x    <= ex_o;
          end_y    <= ey_o;
          depth    <= (cdepth[SW-1:psc_pkg::DEPTH_W] != '0) ?
                      {psc_pkg::DEPTH_W{1'b1}} : cdepth[psc_pkg::DEPTH_W-1:0];
          state    <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

### sv/psc_checker.sv
`default_nettype none
`include "polygon_sat_collision_defines.svh"
module psc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        done,
  input wire logic        collides,
  input wire logic [31:0] start_x,
  input wire logic [31:0] end_x,
  input wire logic [30:0] depth
);

  `PSC_ASSERT_IMP(a_done_idle, done, !busy, "result while busy")
  `PSC_ASSERT_NXT(a_done_pulse, done, !done, "result strobe longer than one cycle")
  `PSC_ASSERT_IMP(a_busy_cause, $rose(busy), $past(start), "busy without an item")
  `PSC_ASSERT_IMP(a_miss_zero, done && !collides,
                  depth == '0 && start_x == '0 && end_x == '0, "miss with nonzero fields")
  `PSC_ASSERT_IMP(a_hit_depth, done && collides, depth != '0, "contact with zero depth")

endmodule

bind polygon_sat_collision psc_checker u_psc_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .collides(collides), .start_x(start_x), .end_x(end_x), .depth(depth)
);
`default_nettype wire

### test/testbench.sv
`timescale 1ns / 100ps
`default_nettype none

module testbench;

  localparam int MAXV = 16;
  localparam int FRAC = 14;
  localparam int WATCHDOG_LIMIT = 40000;
  localparam int RANDOM_ITEMS = 1000;

  typedef struct {
    logic        collides;
    logic [15:0] nx;
    logic [15:0] ny;
    logic [31:0] sx;
    logic [31:0] sy;
    logic [31:0] ex;
    logic [31:0] ey;
    logic [30:0] dep;
  } contact_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic which_polygon = 1'b0;
  logic signed [31:0] vertex_x = '0;
  logic signed [31:0] vertex_y = '0;
  logic last_vertex = 1'b0;
  logic done;
  logic collides;
  logic signed [15:0] normal_x, normal_y;
  logic signed [31:0] start_x, start_y, end_x, end_y;
  logic [30:0] depth;

  polygon_sat_collision dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .which_polygon(which_polygon), .vertex_x(vertex_x), .vertex_y(vertex_y),
    .last_vertex(last_vertex), .done(done), .collides(collides),
    .normal_x(normal_x), .normal_y(normal_y), .start_x(start_x), .start_y(start_y),
    .end_x(end_x), .end_y(end_y), .depth(depth)
  );

  always #6 clk = ~clk;

  // predictor state
  logic signed [31:0] vx [2][MAXV];
  logic signed [31:0] vy [2][MAXV];
  int unsigned vcount [2];
  bit vcomplete [2];

  contact_t contact_q[$];
  int errors = 0;
  int idle_cnt = 0;
  bit gaps_on = 1'b1;

  function automatic longint unsigned isqrt(input longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic void axis_normal(input longint ex, input longint ey,
                                      output longint nx, output longint ny);
    longint unsigned ux, uy, m, len, qx, qy, one;
    one = 64'd1 << FRAC;
    ux = ex < 0 ? -ex : ex;
    uy = ey < 0 ? -ey : ey;
    m = ux > uy ? ux : uy;
    nx = 0;
    ny = 0;
    if (m == 0) return;
    while (m >= (64'd1 << 30)) begin
      ux >>= 1; uy >>= 1; m >>= 1;
    end
    while (m < (64'd1 << 29)) begin
      ux <<= 1; uy <<= 1; m <<= 1;
    end
    len = isqrt(ux * ux + uy * uy);
    qx = (ux * one + len / 2) / len;
    qy = (uy * one + len / 2) / len;
    nx = ey < 0 ? -longint'(qy) : longint'(qy);
    ny = ex < 0 ? longint'(qx) : -longint'(qx);
  endfunction

  function automatic longint axis_separation(input int p, output longint onx,
      output longint ony, output longint opx, output longint opy);
    int q;
    longint best, ax, ay, nx, ny, ms, px, py, bx, by, s;
    int k;
    q = 1 - p;
    best = 0; onx = 0; ony = 0; opx = 0; opy = 0;
    for (int i = 0; i < vcount[p]; i++) begin
      k = (i + 1 == vcount[p]) ? 0 : i + 1;
      ax = vx[p][i];
      ay = vy[p][i];
      axis_normal(longint'(vx[p][k]) - ax, longint'(vy[p][k]) - ay, nx, ny);
      ms = 0; px = 0; py = 0;
      for (int j = 0; j < vcount[q]; j++) begin
        bx = vx[q][j];
        by = vy[q][j];
        s = ((bx - ax) * nx + (by - ay) * ny) >>> FRAC;
        if (j == 0 || s < ms) begin
          ms = s; px = bx; py = by;
        end
      end
      if (i == 0 || ms > best) begin
        best = ms; onx = nx; ony = ny; opx = px; opy = py;
      end
    end
    return best;
  endfunction

  function automatic logic [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic void sat_predict(input logic p, input logic signed [31:0] x,
                                      input logic signed [31:0] y, input logic lst);
    contact_t c;
    longint sab, sba, anx, any, apx, apy, bnx, bny, bpx, bpy;
    longint nx, ny, sx, sy, ex, ey, d, ox, oy;
    if (vcomplete[p]) begin
      vcount[p] = 0;
      vcomplete[p] = 0;
    end
    if (vcount[p] < MAXV) begin
      vx[p][vcount[p]] = x;
      vy[p][vcount[p]] = y;
      vcount[p]++;
    end
    if (lst) vcomplete[p] = 1;
    if (!(vcomplete[0] && vcomplete[1])) return;
    c = '{default: '0};
    sab = axis_separation(0, anx, any, apx, apy);
    sba = axis_separation(1, bnx, bny, bpx, bpy);
    vcount[0] = 0; vcount[1] = 0;
    vcomplete[0] = 0; vcomplete[1] = 0;
    if (sab < 0 && sba < 0) begin
      if (sab > sba) begin
        d = -sab;
        ox = (anx * d) >>> FRAC;
        oy = (any * d) >>> FRAC;
        nx = anx; ny = any;
        sx = apx; sy = apy;
        ex = apx + ox; ey = apy + oy;
      end else begin
        d = -sba;
        ox = (bnx * d) >>> FRAC;
        oy = (bny * d) >>> FRAC;
        nx = -bnx; ny = -bny;
        sx = bpx + ox; sy = bpy + oy;
        ex = bpx; ey = bpy;
      end
      if (d > 64'sd2147483647) d = 64'sd2147483647;
      c.collides = 1'b1;
      c.nx = nx[15:0];
      c.ny = ny[15:0];
      c.sx = clamp32(sx);
      c.sy = clamp32(sy);
      c.ex = clamp32(ex);
      c.ey = clamp32(ey);
      c.dep = d[30:0];
    end
    contact_q.push_back(c);
  endfunction

  task automatic send_vertex(input logic p, input logic signed [31:0] x,
                             input logic signed [31:0] y, input logic lst);
    int gap;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 11);
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    which_polygon = p;
    vertex_x = x;
    vertex_y = y;
    last_vertex = lst;
    start = 1'b1;
    do @(posedge clk); while (busy);
    sat_predict(p, x, y, lst);
    @(negedge clk);
  endtask

  function automatic logic signed [31:0] to_fix(input real v);
    real f;
    f = v * 65536.0;
    if (f > 2147483647.0) return 32'h7FFF_FFFF;
    if (f < -2147483648.0) return 32'h8000_0000;
    return $rtoi(f);
  endfunction

  // convex polygon: points on a circle, counterclockwise, angle jitter
  task automatic send_polygon(input logic p, input real cx, input real cy,
                              input real r, input int n);
    real base, a;
    base = $urandom_range(0, 6283) / 1000.0;
    for (int k = 0; k < n; k++) begin
      a = base + 6.2831853 * (k + 0.6 * $urandom_range(0, 1000) / 1000.0) / n;
      send_vertex(p, to_fix(cx + r * $cos(a)), to_fix(cy + r * $sin(a)), k == n - 1);
    end
  endtask

  task automatic send_box(input logic p, input int x0, input int y0,
                          input int x1, input int y1);
    send_vertex(p, x0, y0, 1'b0);
    send_vertex(p, x1, y0, 1'b0);
    send_vertex(p, x1, y1, 1'b0);
    send_vertex(p, x0, y1, 1'b1);
  endtask

  task automatic test_overlap_and_gap();
    send_box(0, 0, 0, 32'sh0004_0000, 32'sh0004_0000);
    send_box(1, 32'sh0003_0000, 32'sh0001_0000, 32'sh0006_0000, 32'sh0002_0000);
    send_box(1, 32'sh0010_0000, 0, 32'sh0012_0000, 32'sh0002_0000);
    send_box(0, 0, 0, 32'sh0004_0000, 32'sh0004_0000);
  endtask

  task automatic test_degenerate();
    // repeated vertex gives a zero-length edge; single-vertex polygons
    send_vertex(0, 0, 0, 1'b0);
    send_vertex(0, 0, 0, 1'b0);
    send_vertex(0, 32'sh0004_0000, 0, 1'b0);
    send_vertex(0, 0, 32'sh0004_0000, 1'b1);
    send_vertex(1, 32'sh0001_0000, 32'sh0001_0000, 1'b1);
    send_vertex(1, 32'sh0000_8000, 32'sh0000_8000, 1'b1);
    send_vertex(0, 32'sh0000_8000, 32'sh0000_8000, 1'b1);
  endtask

  task automatic test_extremes();
    send_vertex(0, 32'sh8000_0000, 32'sh8000_0000, 1'b0);
    send_vertex(0, 32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0);
    send_vertex(0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0);
    send_vertex(0, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b1);
    send_vertex(1, 32'sh8000_0000, 32'sh8000_0000, 1'b0);
    send_vertex(1, 32'sh7FFF_FFFF, 0, 1'b0);
    send_vertex(1, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b1);
  endtask

  task automatic test_capacity_and_restart();
    send_polygon(0, 0.0, 0.0, 100.0, 20);
    send_polygon(1, 0.0, 0.0, 30.0, 3);
    send_polygon(1, 500.0, 0.0, 50.0, 4);
    send_polygon(1, 10.0, 5.0, 50.0, 5);
    send_polygon(0, 20.0, 0.0, 40.0, 6);
  endtask

  task automatic test_random_shapes(input int items);
    int sent, na, nb;
    real cx, cy, r, spread;
    sent = 0;
    while (sent < items) begin
      gaps_on = sent < items * 3 / 4;
      case ($urandom_range(0, 9))
        0: begin
          for (int i = 0; i < 8; i++) begin
            send_vertex($urandom_range(0, 1), $urandom, $urandom, $urandom_range(0, 3) == 0);
            sent++;
          end
        end
        1: begin
          na = $urandom_range(1, 20);
          nb = $urandom_range(1, 4);
          send_polygon(0, 0.0, 0.0, 8000.0 + $urandom_range(0, 20000), na);
          send_polygon(1, 30000.0 - $urandom_range(0, 60000), 0.0, 5000.0, nb);
          sent += na + nb;
        end
        default: begin
          na = $urandom_range(0, 3) == 0 ? $urandom_range(3, 16) : $urandom_range(3, 6);
          nb = $urandom_range(0, 3) == 0 ? $urandom_range(3, 16) : $urandom_range(3, 6);
          spread = $urandom_range(0, 1) ? 1000.0 : 10.0;
          r = $urandom_range(1, 1000) * spread / 1000.0;
          cx = ($itor($urandom_range(0, 2000)) - 1000.0) * spread / 1000.0;
          cy = ($itor($urandom_range(0, 2000)) - 1000.0) * spread / 1000.0;
          if ($urandom_range(0, 1)) begin
            send_polygon(0, 0.0, 0.0, r, na);
            send_polygon(1, cx, cy, r * $urandom_range(2, 20) / 10.0, nb);
          end else begin
            send_polygon(1, 0.0, 0.0, r, nb);
            send_polygon(0, cx, cy, r * $urandom_range(2, 20) / 10.0, na);
          end
          sent += na + nb;
        end
      endcase
    end
    // close out any half-loaded pair
    send_vertex(0, 0, 0, 1'b1);
    send_vertex(1, 0, 0, 1'b1);
  endtask

  task automatic report(input string field, input longint exp, input longint act);
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, exp, act);
    errors++;
  endtask

  always @(posedge clk) begin
    contact_t c;
    if (!rst && done) begin
      if (contact_q.size() == 0) begin
        $display("%0t: unexpected result, collides %0b", $time, collides);
        errors++;
      end else begin
        c = contact_q.pop_front();
        if (collides !== c.collides) report("collides", c.collides, collides);
        if (normal_x !== c.nx) report("normal_x", c.nx, normal_x);
        if (normal_y !== c.ny) report("normal_y", c.ny, normal_y);
        if (start_x !== c.sx) report("start_x", c.sx, start_x);
        if (start_y !== c.sy) report("start_y", c.sy, start_y);
        if (end_x !== c.ex) report("end_x", c.ex, end_x);
        if (end_y !== c.ey) report("end_y", c.ey, end_y);
        if (depth !== c.dep) report("depth", c.dep, depth);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || done || (start && !busy)) begin
      idle_cnt <= 0;
    end else begin
      idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= WATCHDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    vcount[0] = 0; vcount[1] = 0;
    vcomplete[0] = 0; vcomplete[1] = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_overlap_and_gap();
    test_degenerate();
    test_extremes();
    test_capacity_and_restart();
    test_random_shapes(RANDOM_ITEMS);
    start = 1'b0;
    while (contact_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

### filelist.f
+incdir+sv
sv/psc_pkg.sv
sv/psc_ram.sv
sv/psc_norm.sv
sv/polygon_sat_collision.sv
sv/psc_checker.sv
test/testbench.sv
